/* sv/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// lzd_pkg
// shared types, constants and tables of the lz77 bit-stream decompressor
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

   localparam int WINDOW_BITS = 21;
   localparam int WIN_DEPTH   = 1 << WINDOW_BITS;
   localparam int LEN_W       = 10;
   localparam int CNT_W       = 5;
   localparam int GROUP_BYTES = 16;
   localparam int GROUP_W     = GROUP_BYTES * 8;
   localparam int ADDR_W      = 2;

   localparam logic [ADDR_W-1:0] REG_TOTAL_LENGTH = 2'd0;

   typedef enum logic [2:0] {
      PH_FLAG,
      PH_LIT,
      PH_PREFIX,
      PH_EXTRA,
      PH_SLOT,
      PH_DIST
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_MATCH,
      CMD_ERR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [7:0]             lit;
      logic [LEN_W-1:0]       len;
      logic [WINDOW_BITS-1:0] offset;
      logic                   done;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } qpush_type;

   typedef struct packed {
      logic    full;
      logic    empty;
      cmd_type head;
   } qstat_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DECODE,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_WRITE,
      B_EMIT
   } back_state_type;

   function automatic logic [4:0] class_width(input logic [2:0] c);
      logic [4:0] r;
      case (c)
         3'd0: r = 5'd2;
         3'd1: r = 5'd2;
         3'd2: r = 5'd2;
         3'd3: r = 5'd3;
         3'd4: r = 5'd5;
         default: r = 5'd9;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] class_base(input logic [2:0] c);
      logic [5:0] r;
      case (c)
         3'd0: r = 6'd0;
         3'd1: r = 6'd4;
         3'd2: r = 6'd8;
         3'd3: r = 6'd12;
         3'd4: r = 6'd20;
         default: r = 6'd52;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/lzd_req_if.sv */
// ----------------------------------------------------------------------------
// lzd_req_if
// compressed byte channel, one byte per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface lzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* sv/lzd_rsp_if.sv */
// ----------------------------------------------------------------------------
// lzd_rsp_if
// decoded group channel, up to sixteen bytes per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface lzd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] bytes_low;
   logic [63:0] bytes_high;
   logic [4:0]  byte_count;
   logic        last;
   logic        done_res;
   logic        error;

   modport source (output valid, output bytes_low, output bytes_high, output byte_count,
                   output last, output done_res, output error, input ready);
   modport sink (input valid, input bytes_low, input bytes_high, input byte_count,
                 input last, input done_res, input error, output ready);
endinterface

`default_nettype wire

/* sv/lzd_front.sv */
// ----------------------------------------------------------------------------
// lzd_front
// bit accumulator and token parser, one field per cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   lzd_req_if.sink                req,
   input  wire logic [31:0]       total_length,
   input  wire lzd_pkg::qstat_type qstat,
   output lzd_pkg::qpush_type     qpush
);

   lzd_pkg::front_state_type state_ff, state_in;
   lzd_pkg::phase_type       phase_ff, phase_in;
   logic [31:0]              acc_ff, acc_in;
   logic [5:0]               held_ff, held_in;
   logic [lzd_pkg::LEN_W-1:0] ml_ff, ml_in;
   logic [3:0]               slot_ff, slot_in;
   logic [31:0]              produced_ff, produced_in;
   logic                     done_ff, done_in;
   logic                     err_ff, err_in;
   lzd_pkg::cmd_type         cmd_ff, cmd_in;

   logic                     accept;
   logic [4:0]               w;
   logic [31:0]              v;
   logic [lzd_pkg::WINDOW_BITS-1:0] offset;
   logic [lzd_pkg::LEN_W-1:0] len;
   logic [32:0]              end_pos;
   logic                     bad;
   logic                     enough;
   logic [lzd_pkg::LEN_W-1:0] ml_inc;

   assign req.ready = (state_ff == lzd_pkg::F_IDLE);
   assign accept    = req.valid && req.ready;

   always_comb begin
      case (phase_ff)
         lzd_pkg::PH_LIT:   w = 5'd8;
         lzd_pkg::PH_EXTRA: w = lzd_pkg::class_width(ml_ff[2:0]);
         lzd_pkg::PH_SLOT:  w = 5'd4;
         lzd_pkg::PH_DIST:  w = (slot_ff == 4'd0) ? 5'(lzd_pkg::WINDOW_BITS - 15)
                                                 : 5'(lzd_pkg::WINDOW_BITS - 16) + 5'(slot_ff);
         default:           w = 5'd1;
      endcase
   end

   assign enough  = held_ff >= {1'b0, w};
   assign v       = acc_ff & ((32'h1 << w) - 32'h1);
   assign offset  = lzd_pkg::WINDOW_BITS'(v)
                    + ((slot_ff == 4'd0) ? '0
                       : (lzd_pkg::WINDOW_BITS'(1) << (5'(lzd_pkg::WINDOW_BITS - 16)
                                                       + 5'(slot_ff))));
   assign len     = ml_ff + lzd_pkg::LEN_W'(3);
   assign end_pos = {1'b0, produced_ff} + 33'(len);
   assign bad     = (32'(offset) >= produced_ff) || (end_pos > {1'b0, total_length});
   assign ml_inc  = ml_ff + lzd_pkg::LEN_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzd_pkg::F_IDLE: begin
            if (accept) begin
               if (err_ff) begin
                  state_in = lzd_pkg::F_PUSH;
               end else if (!(done_ff || produced_ff >= total_length)) begin
                  state_in = lzd_pkg::F_DECODE;
               end
            end
         end
         lzd_pkg::F_DECODE: begin
            if (!enough) begin
               state_in = lzd_pkg::F_IDLE;
            end else if (phase_ff == lzd_pkg::PH_LIT || phase_ff == lzd_pkg::PH_DIST) begin
               state_in = lzd_pkg::F_PUSH;
            end
         end
         lzd_pkg::F_PUSH: begin
            if (!qstat.full) begin
               state_in = lzd_pkg::F_IDLE;
            end
         end
         default: state_in = lzd_pkg::F_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      held_in     = held_ff;
      ml_in       = ml_ff;
      slot_in     = slot_ff;
      produced_in = produced_ff;
      done_in     = done_ff;
      err_in      = err_ff;
      cmd_in      = cmd_ff;
      qpush.push  = 1'b0;
      qpush.cmd   = cmd_ff;
      case (state_ff)
         lzd_pkg::F_IDLE: begin
            if (accept) begin
               if (err_ff) begin
                  cmd_in      = '0;
                  cmd_in.kind = lzd_pkg::CMD_ERR;
               end else if (done_ff || produced_ff >= total_length) begin
                  done_in = 1'b1;
               end else begin
                  acc_in  = acc_ff | (32'(req.in_byte) << held_ff);
                  held_in = held_ff + 6'd8;
               end
            end
         end
         lzd_pkg::F_DECODE: begin
            if (enough) begin
               acc_in  = acc_ff >> w;
               held_in = held_ff - 6'(w);
               case (phase_ff)
                  lzd_pkg::PH_FLAG: begin
                     if (v[0]) begin
                        phase_in = lzd_pkg::PH_PREFIX;
                        ml_in    = '0;
                     end else begin
                        phase_in = lzd_pkg::PH_LIT;
                     end
                  end
                  lzd_pkg::PH_LIT: begin
                     produced_in = produced_ff + 32'd1;
                     cmd_in      = '0;
                     cmd_in.kind = lzd_pkg::CMD_LIT;
                     cmd_in.lit  = v[7:0];
                     cmd_in.done = (produced_ff + 32'd1) >= total_length;
                     done_in     = done_ff | cmd_in.done;
                     phase_in    = lzd_pkg::PH_FLAG;
                  end
                  lzd_pkg::PH_PREFIX: begin
                     if (v[0]) begin
                        phase_in = lzd_pkg::PH_EXTRA;
                     end else if (ml_inc >= lzd_pkg::LEN_W'(5)) begin
                        ml_in    = lzd_pkg::LEN_W'(5);
                        phase_in = lzd_pkg::PH_EXTRA;
                     end else begin
                        ml_in = ml_inc;
                     end
                  end
                  lzd_pkg::PH_EXTRA: begin
                     ml_in    = lzd_pkg::LEN_W'(lzd_pkg::class_base(ml_ff[2:0]))
                                + lzd_pkg::LEN_W'(v[8:0]);
                     phase_in = lzd_pkg::PH_SLOT;
                  end
                  lzd_pkg::PH_SLOT: begin
                     slot_in  = v[3:0];
                     phase_in = lzd_pkg::PH_DIST;
                  end
                  lzd_pkg::PH_DIST: begin
                     phase_in = lzd_pkg::PH_FLAG;
                     cmd_in   = '0;
                     if (bad) begin
                        err_in      = 1'b1;
                        cmd_in.kind = lzd_pkg::CMD_ERR;
                     end else begin
                        cmd_in.kind   = lzd_pkg::CMD_MATCH;
                        cmd_in.len    = len;
                        cmd_in.offset = offset;
                        cmd_in.done   = end_pos >= {1'b0, total_length};
                        produced_in   = end_pos[31:0];
                        done_in       = done_ff | cmd_in.done;
                     end
                  end
                  default: phase_in = lzd_pkg::PH_FLAG;
               endcase
            end
         end
         lzd_pkg::F_PUSH: begin
            qpush.push = !qstat.full;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lzd_pkg::F_IDLE;
         phase_ff    <= lzd_pkg::PH_FLAG;
         acc_ff      <= '0;
         held_ff     <= '0;
         ml_ff       <= '0;
         slot_ff     <= '0;
         produced_ff <= '0;
         done_ff     <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         held_ff     <= held_in;
         ml_ff       <= ml_in;
         slot_ff     <= slot_in;
         produced_ff <= produced_in;
         done_ff     <= done_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

/* sv/lzd_queue.sv */
// ----------------------------------------------------------------------------
// lzd_queue
// two-entry command queue between parser and copy engine
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lzd_pkg::qpush_type qpush,
   input  wire logic               pop,
   output lzd_pkg::qstat_type      qstat
);

   lzd_pkg::cmd_type entry_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign qstat.full  = count_ff == 2'd2;
   assign qstat.empty = count_ff == 2'd0;
   assign qstat.head  = entry_ff[rptr_ff];
   assign do_push     = qpush.push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;

   always_comb begin
      wptr_in  = do_push ? ~wptr_ff : wptr_ff;
      rptr_in  = do_pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= qpush.cmd;
      end
   end

endmodule

`default_nettype wire

/* sv/lzd_back.sv */
// ----------------------------------------------------------------------------
// lzd_back
// copy engine: history window, byte-serial match copy, group packing
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lzd_pkg::qstat_type qstat,
   output logic                    pop,
   lzd_rsp_if.source               rsp
);

   localparam int WB = lzd_pkg::WINDOW_BITS;

   logic [7:0] mem [lzd_pkg::WIN_DEPTH];

   lzd_pkg::back_state_type state_ff, state_in;
   logic [WB-1:0]            wptr_ff, wptr_in;
   logic [WB-1:0]            src_ff, src_in;
   logic [lzd_pkg::LEN_W-1:0] remain_ff, remain_in;
   logic [lzd_pkg::GROUP_W-1:0] group_ff, group_in;
   logic [lzd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic                     err_ff, err_in;
   logic [7:0]               rdata_ff;

   logic                     out_valid_ff, out_valid_in;
   logic [63:0]              out_low_ff, out_high_ff;
   logic [lzd_pkg::CNT_W-1:0] out_cnt_ff;
   logic                     out_last_ff, out_done_ff, out_err_ff;

   logic                     we;
   logic [7:0]               wdata;
   logic                     re;
   logic                     load;
   logic                     out_free;

   assign out_free = !out_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzd_pkg::B_IDLE: begin
            if (!qstat.empty) begin
               state_in = (qstat.head.kind == lzd_pkg::CMD_MATCH) ? lzd_pkg::B_READ
                                                                 : lzd_pkg::B_EMIT;
            end
         end
         lzd_pkg::B_READ: state_in = lzd_pkg::B_WRITE;
         lzd_pkg::B_WRITE: begin
            if (remain_ff == lzd_pkg::LEN_W'(1) || cnt_ff == lzd_pkg::CNT_W'(15)) begin
               state_in = lzd_pkg::B_EMIT;
            end else begin
               state_in = lzd_pkg::B_READ;
            end
         end
         lzd_pkg::B_EMIT: begin
            if (out_free) begin
               state_in = (remain_ff == '0) ? lzd_pkg::B_IDLE : lzd_pkg::B_READ;
            end
         end
         default: state_in = lzd_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wptr_in   = wptr_ff;
      src_in    = src_ff;
      remain_in = remain_ff;
      group_in  = group_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      err_in    = err_ff;
      we        = 1'b0;
      wdata     = rdata_ff;
      re        = 1'b0;
      pop       = 1'b0;
      load      = 1'b0;
      case (state_ff)
         lzd_pkg::B_IDLE: begin
            if (!qstat.empty) begin
               pop       = 1'b1;
               done_in   = qstat.head.done;
               err_in    = 1'b0;
               remain_in = '0;
               group_in  = '0;
               cnt_in    = '0;
               case (qstat.head.kind)
                  lzd_pkg::CMD_LIT: begin
                     we       = 1'b1;
                     wdata    = qstat.head.lit;
                     wptr_in  = wptr_ff + WB'(1);
                     group_in = lzd_pkg::GROUP_W'(qstat.head.lit);
                     cnt_in   = lzd_pkg::CNT_W'(1);
                  end
                  lzd_pkg::CMD_MATCH: begin
                     remain_in = qstat.head.len;
                     src_in    = wptr_ff - WB'(1) - qstat.head.offset;
                  end
                  default: begin
                     err_in  = 1'b1;
                     done_in = 1'b0;
                  end
               endcase
            end
         end
         lzd_pkg::B_READ: begin
            re     = 1'b1;
            src_in = src_ff + WB'(1);
         end
         lzd_pkg::B_WRITE: begin
            we        = 1'b1;
            wptr_in   = wptr_ff + WB'(1);
            group_in  = group_ff
                        | (lzd_pkg::GROUP_W'(rdata_ff) << {cnt_ff[3:0], 3'b000});
            cnt_in    = cnt_ff + lzd_pkg::CNT_W'(1);
            remain_in = remain_ff - lzd_pkg::LEN_W'(1);
         end
         lzd_pkg::B_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               group_in = '0;
               cnt_in   = '0;
            end
         end
         default: ;
      endcase
      out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzd_pkg::B_IDLE;
         wptr_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      remain_ff <= remain_in;
      group_ff  <= group_in;
      cnt_ff    <= cnt_in;
      done_ff   <= done_in;
      err_ff    <= err_in;
      if (load) begin
         out_low_ff  <= group_ff[63:0];
         out_high_ff <= group_ff[127:64];
         out_cnt_ff  <= cnt_ff;
         out_last_ff <= remain_ff == '0;
         out_done_ff <= done_ff;
         out_err_ff  <= err_ff;
      end
   end

   // history window
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wptr_ff] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[src_ff];
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.bytes_low  = out_low_ff;
   assign rsp.bytes_high = out_high_ff;
   assign rsp.byte_count = out_cnt_ff;
   assign rsp.last       = out_last_ff;
   assign rsp.done_res   = out_done_ff;
   assign rsp.error      = out_err_ff;

endmodule

`default_nettype wire

/* sv/lz77_bitstream_decompressor.sv */
// ----------------------------------------------------------------------------
// lz77_bitstream_decompressor
// lsb-first lz77 bit-stream decoder with 2 MiB history and 16-byte result beats
// ----------------------------------------------------------------------------
// A compressed byte is taken while the parser is idle; the parser then decodes
// the token fields held in the bit accumulator, one field per cycle, goes back
// for a byte after each token or a short field, waits while the queue is full
// and hands finished tokens through a two-entry queue to the copy engine. The
// engine writes a literal to the history window and emits it as a one-byte beat;
// for a match it reads and writes each copied byte in turn through the
// single-port history window and emits a beat when sixteen bytes are
// packed or the 3..566 byte copy ends. Set total_length before the first byte;
// once it is reached, or a bad distance or overrun is seen, further bytes give
// no beat or one error beat each until reset.
`default_nettype none

module lz77_bitstream_decompressor (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lzd_req_if.sink                         req,
   lzd_rsp_if.source                       rsp,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [lzd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   logic [31:0]        total_ff, total_in;
   lzd_pkg::qpush_type qpush;
   lzd_pkg::qstat_type qstat;
   logic               pop;

   assign pready = 1'b1;
   assign prdata = (paddr == lzd_pkg::REG_TOTAL_LENGTH) ? total_ff : 32'd0;

   always_comb begin
      total_in = total_ff;
      if (psel && penable && pwrite && paddr == lzd_pkg::REG_TOTAL_LENGTH) begin
         total_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   lzd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .total_length (total_ff),
      .qstat        (qstat),
      .qpush        (qpush)
   );

   lzd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qpush (qpush),
      .pop   (pop),
      .qstat (qstat)
   );

   lzd_back u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp)
   );

   a_err_beat : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.error |-> rsp.last && !rsp.done_res && rsp.byte_count == 5'd0)
      else $error("error beat malformed");

   a_data_beat : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.error |-> rsp.byte_count != 5'd0 && rsp.byte_count <= 5'd16)
      else $error("data beat byte count out of range");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("command popped from empty queue");

endmodule

`default_nettype wire
